// ===== src/wmgf_pkg.sv =====
// Shared types and constants for the windowed mean gap filler.
`default_nettype none

package wmgf_pkg;

   localparam int WINDOW_BITS    = 5;
   localparam int WINDOW_RESET   = 5;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int REG_INDEX_BITS = 1;

   localparam logic [REG_INDEX_BITS-1:0] REG_WINDOW_ROWS = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_HEAD_RD,
      ST_HEAD_WAIT,
      ST_SCAN,
      ST_DIVIDE,
      ST_EMIT
   } wmgf_state_type;

   typedef struct packed {
      logic push;
      logic finish;
      logic head_rd;
      logic head_load;
      logic scan_step;
      logic div_start;
      logic div_step;
      logic emit;
   } wmgf_cmd_type;

   typedef struct packed {
      logic emit_due;
      logic head_absent;
      logic scan_done;
      logic div_done;
      logic out_free;
   } wmgf_status_type;

endpackage

`default_nettype wire

// ===== src/wmgf_req_if.sv =====
// Request channel interface: one sample per request.
`default_nettype none

interface wmgf_req_if #(
   parameter int SAMPLE_BITS = 48
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_value;
   logic                   sample_missing;
   logic                   last_sample;

   modport source (output valid, sample_value, sample_missing, last_sample, input ready);
   modport sink   (input valid, sample_value, sample_missing, last_sample, output ready);
endinterface

`default_nettype wire

// ===== src/wmgf_rsp_if.sv =====
// Result channel interface: one emitted row per transfer.
`default_nettype none

interface wmgf_rsp_if #(
   parameter int SAMPLE_BITS = 48
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] out_value;
   logic                   out_filled;
   logic                   out_last;

   modport source (output valid, out_value, out_filled, out_last, input ready);
   modport sink   (input valid, out_value, out_filled, out_last, output ready);
endinterface

`default_nettype wire

// ===== src/wmgf_ram.sv =====
// Generic single write port, single registered read port RAM.
`default_nettype none

module wmgf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/wmgf_ctrl.sv =====
// Sequencer: accepts a request, then emits due rows one at a time.
`default_nettype none

module wmgf_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire wmgf_pkg::wmgf_status_type status,
   output wmgf_pkg::wmgf_cmd_type         cmd
);

   wmgf_pkg::wmgf_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wmgf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wmgf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = wmgf_pkg::ST_CHECK;
            end
         end
         wmgf_pkg::ST_CHECK: begin
            state_in = status.emit_due ? wmgf_pkg::ST_HEAD_RD : wmgf_pkg::ST_IDLE;
         end
         wmgf_pkg::ST_HEAD_RD: begin
            state_in = wmgf_pkg::ST_HEAD_WAIT;
         end
         wmgf_pkg::ST_HEAD_WAIT: begin
            state_in = status.head_absent ? wmgf_pkg::ST_SCAN : wmgf_pkg::ST_EMIT;
         end
         wmgf_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = wmgf_pkg::ST_DIVIDE;
            end
         end
         wmgf_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = wmgf_pkg::ST_EMIT;
            end
         end
         wmgf_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = wmgf_pkg::ST_CHECK;
            end
         end
         default: begin
            state_in = wmgf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         wmgf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.push  = req_valid;
         end
         wmgf_pkg::ST_CHECK: begin
            cmd.finish = !status.emit_due;
         end
         wmgf_pkg::ST_HEAD_RD: begin
            cmd.head_rd = 1'b1;
         end
         wmgf_pkg::ST_HEAD_WAIT: begin
            cmd.head_load = 1'b1;
         end
         wmgf_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.div_start = status.scan_done;
         end
         wmgf_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         wmgf_pkg::ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/wmgf_datapath.sv =====
// Datapath: pending and history buffers, neighbor sum, serial divider, output register.
`default_nettype none

module wmgf_datapath #(
   parameter int MAX_WINDOW  = 16,
   parameter int SAMPLE_BITS = 48
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [wmgf_pkg::WINDOW_BITS-1:0] window_rows,
   input  wire logic [SAMPLE_BITS-1:0]           req_value,
   input  wire logic                             req_missing,
   input  wire logic                             req_last,
   input  wire wmgf_pkg::wmgf_cmd_type           cmd,
   output wmgf_pkg::wmgf_status_type             status,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [SAMPLE_BITS-1:0]                rsp_value,
   output logic                                  rsp_filled,
   output logic                                  rsp_last
);

   localparam int PEND_DEPTH = MAX_WINDOW + 1;
   localparam int PEND_ABITS = $clog2(PEND_DEPTH);
   localparam int FILL_BITS  = $clog2(PEND_DEPTH + 1);
   localparam int HIST_ABITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int HFILL_BITS = $clog2(MAX_WINDOW + 1);
   localparam int CNT_BITS   = $clog2(2 * MAX_WINDOW + 1);
   localparam int SUM_RAW    = SAMPLE_BITS + $clog2(2 * MAX_WINDOW);
   localparam int SUM_BITS   = (SUM_RAW > 64) ? 64 : SUM_RAW;
   localparam int DCNT_BITS  = $clog2(SUM_BITS + 1);
   localparam int CALC_BITS  = (CNT_BITS + 2 > wmgf_pkg::WINDOW_BITS) ?
                               CNT_BITS + 2 : wmgf_pkg::WINDOW_BITS + 1;
   localparam int PEND_WIDTH = SAMPLE_BITS + 1;

   // control registers
   logic [FILL_BITS-1:0]  pf_ff, pf_in;
   logic [PEND_ABITS-1:0] hd_ff, hd_in;
   logic [HFILL_BITS-1:0] hf_ff, hf_in;
   logic [HIST_ABITS-1:0] hw_ff, hw_in;
   logic                  last_ff, last_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [DCNT_BITS-1:0]  dcnt_ff, dcnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [SAMPLE_BITS-1:0] cur_val_ff, cur_val_in;
   logic                   cur_absent_ff, cur_absent_in;
   logic [CNT_BITS-1:0]    nb_ff, nb_in;
   logic [CNT_BITS-1:0]    tot_ff, tot_in;
   logic [CNT_BITS-1:0]    k_ff, k_in;
   logic                   rd_hist_ff, rd_hist_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic [SUM_BITS-1:0]    quo_ff, quo_in;
   logic [CNT_BITS-1:0]    rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_filled_ff, rsp_filled_in;
   logic                   rsp_last_ff, rsp_last_in;

   // buffer ports
   logic                   pend_wr_en, pend_rd_en;
   logic [PEND_ABITS-1:0]  pend_wr_addr, pend_rd_addr;
   logic [PEND_WIDTH-1:0]  pend_wr_data, pend_q;
   logic                   hist_rd_en;
   logic [HIST_ABITS-1:0]  hist_rd_addr;
   logic [SAMPLE_BITS-1:0] hist_q;

   logic [CALC_BITS-1:0]   w_calc;
   logic [CALC_BITS-1:0]   tail_sum, pend_scan_sum, hist_scan_sum;
   logic [CALC_BITS-1:0]   nb_calc, nf_calc, hf_calc, pf_less;
   logic                   scan_more, scan_hist;
   logic                   out_free;
   logic [CNT_BITS:0]      div_shift;
   logic                   div_bit;
   logic [SAMPLE_BITS-1:0] fill_value, emit_value;

   wmgf_ram #(
      .WIDTH (PEND_WIDTH),
      .DEPTH (PEND_DEPTH)
   ) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_wr_en),
      .wr_addr (pend_wr_addr),
      .wr_data (pend_wr_data),
      .rd_en   (pend_rd_en),
      .rd_addr (pend_rd_addr),
      .rd_data (pend_q)
   );

   wmgf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.emit),
      .wr_addr (hw_ff),
      .wr_data (emit_value),
      .rd_en   (hist_rd_en),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_q)
   );

   // effective window, saturated at the buffer depth
   always_comb begin
      if (CALC_BITS'(window_rows) > CALC_BITS'(MAX_WINDOW)) begin
         w_calc = CALC_BITS'(MAX_WINDOW);
      end else begin
         w_calc = CALC_BITS'(window_rows);
      end
   end

   // circular addressing
   always_comb begin
      tail_sum = CALC_BITS'(hd_ff) + CALC_BITS'(pf_ff);
      if (tail_sum >= CALC_BITS'(PEND_DEPTH)) begin
         tail_sum = tail_sum - CALC_BITS'(PEND_DEPTH);
      end
      pend_scan_sum = CALC_BITS'(hd_ff) + CALC_BITS'(1) + CALC_BITS'(k_ff) - CALC_BITS'(nb_ff);
      if (pend_scan_sum >= CALC_BITS'(PEND_DEPTH)) begin
         pend_scan_sum = pend_scan_sum - CALC_BITS'(PEND_DEPTH);
      end
      hist_scan_sum = CALC_BITS'(hw_ff) + CALC_BITS'(MAX_WINDOW - 1) - CALC_BITS'(k_ff);
      if (hist_scan_sum >= CALC_BITS'(MAX_WINDOW)) begin
         hist_scan_sum = hist_scan_sum - CALC_BITS'(MAX_WINDOW);
      end
   end

   assign scan_more = cmd.scan_step && (k_ff < tot_ff);
   assign scan_hist = k_ff < nb_ff;

   assign pend_wr_en   = cmd.push;
   assign pend_wr_addr = PEND_ABITS'(tail_sum);
   assign pend_wr_data = {req_missing, req_missing ? '0 : req_value};
   assign pend_rd_en   = cmd.head_rd || (scan_more && !scan_hist);
   assign pend_rd_addr = cmd.head_rd ? hd_ff : PEND_ABITS'(pend_scan_sum);
   assign hist_rd_en   = scan_more && scan_hist;
   assign hist_rd_addr = HIST_ABITS'(hist_scan_sum);

   // neighbor counts on each side
   always_comb begin
      hf_calc = CALC_BITS'(hf_ff);
      pf_less = CALC_BITS'(pf_ff) - CALC_BITS'(1);
      nb_calc = (hf_calc < w_calc) ? hf_calc : w_calc;
      nf_calc = (pf_less < w_calc) ? pf_less : w_calc;
   end

   assign div_shift = {rem_ff, quo_ff[SUM_BITS-1]};
   assign div_bit   = div_shift >= {1'b0, cnt_ff};

   always_comb begin
      if (cnt_ff == '0) begin
         fill_value = '0;
      end else begin
         fill_value = SAMPLE_BITS'(neg_ff ? -quo_ff : quo_ff);
      end
      emit_value = cur_absent_ff ? fill_value : cur_val_ff;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      pf_in         = pf_ff;
      hd_in         = hd_ff;
      hf_in         = hf_ff;
      hw_in         = hw_ff;
      last_in       = last_ff;
      rd_valid_in   = rd_valid_ff;
      dcnt_in       = dcnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      cur_val_in    = cur_val_ff;
      cur_absent_in = cur_absent_ff;
      nb_in         = nb_ff;
      tot_in        = tot_ff;
      k_in          = k_ff;
      rd_hist_in    = rd_hist_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_filled_in = rsp_filled_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.push) begin
         pf_in   = pf_ff + FILL_BITS'(1);
         last_in = req_last;
      end

      if (cmd.finish && last_ff) begin
         hf_in   = '0;
         hd_in   = '0;
         last_in = 1'b0;
      end

      if (cmd.head_load) begin
         cur_val_in    = pend_q[SAMPLE_BITS-1:0];
         cur_absent_in = pend_q[SAMPLE_BITS];
         nb_in         = CNT_BITS'(nb_calc);
         tot_in        = CNT_BITS'(nb_calc + nf_calc);
         k_in          = '0;
         sum_in        = '0;
         cnt_in        = '0;
         rd_valid_in   = 1'b0;
      end

      // accumulate the word read in the previous cycle
      if (rd_valid_ff) begin
         if (rd_hist_ff) begin
            sum_in = sum_ff + SUM_BITS'($signed(hist_q));
            cnt_in = cnt_ff + CNT_BITS'(1);
         end else if (!pend_q[SAMPLE_BITS]) begin
            sum_in = sum_ff + SUM_BITS'($signed(pend_q[SAMPLE_BITS-1:0]));
            cnt_in = cnt_ff + CNT_BITS'(1);
         end
      end

      if (cmd.scan_step) begin
         rd_valid_in = scan_more;
         rd_hist_in  = scan_hist;
         if (scan_more) begin
            k_in = k_ff + CNT_BITS'(1);
         end
      end

      if (cmd.div_start) begin
         neg_in  = sum_ff[SUM_BITS-1];
         quo_in  = sum_ff[SUM_BITS-1] ? -sum_ff : sum_ff;
         rem_in  = '0;
         dcnt_in = DCNT_BITS'(SUM_BITS);
      end

      if (cmd.div_step && (dcnt_ff != '0)) begin
         if (div_bit) begin
            rem_in = CNT_BITS'(div_shift - {1'b0, cnt_ff});
         end else begin
            rem_in = div_shift[CNT_BITS-1:0];
         end
         quo_in  = {quo_ff[SUM_BITS-2:0], div_bit};
         dcnt_in = dcnt_ff - DCNT_BITS'(1);
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = emit_value;
         rsp_filled_in = cur_absent_ff;
         rsp_last_in   = last_ff && (pf_ff == FILL_BITS'(1));
         hw_in = (hw_ff == HIST_ABITS'(MAX_WINDOW - 1)) ? '0 : hw_ff + HIST_ABITS'(1);
         if (hf_ff != HFILL_BITS'(MAX_WINDOW)) begin
            hf_in = hf_ff + HFILL_BITS'(1);
         end
         hd_in = (hd_ff == PEND_ABITS'(PEND_DEPTH - 1)) ? '0 : hd_ff + PEND_ABITS'(1);
         pf_in = pf_ff - FILL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pf_ff        <= '0;
         hd_ff        <= '0;
         hf_ff        <= '0;
         hw_ff        <= '0;
         last_ff      <= 1'b0;
         rd_valid_ff  <= 1'b0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pf_ff        <= pf_in;
         hd_ff        <= hd_in;
         hf_ff        <= hf_in;
         hw_ff        <= hw_in;
         last_ff      <= last_in;
         rd_valid_ff  <= rd_valid_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_val_ff    <= cur_val_in;
      cur_absent_ff <= cur_absent_in;
      nb_ff         <= nb_in;
      tot_ff        <= tot_in;
      k_ff          <= k_in;
      rd_hist_ff    <= rd_hist_in;
      sum_ff        <= sum_in;
      cnt_ff        <= cnt_in;
      neg_ff        <= neg_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_filled_ff <= rsp_filled_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      status.emit_due    = last_ff ? (pf_ff != '0) : (CALC_BITS'(pf_ff) > w_calc);
      status.head_absent = pend_q[SAMPLE_BITS];
      status.scan_done   = (k_ff == tot_ff) && !rd_valid_ff;
      status.div_done    = dcnt_ff == '0;
      status.out_free    = out_free;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_filled = rsp_filled_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

// ===== src/windowed_mean_gap_filler_top.sv =====
// Top level of the windowed mean gap filler: channels, window register, sequencer, datapath.
// Streams a column of signed Q32.16 samples and replaces each missing one with the mean
// (truncated toward zero) of up to W earlier emitted rows and up to W later present rows,
// or zero if there is none; rows come out W requests late, and a request marked last
// flushes the column and clears its history. Requests are taken one at a time; a present
// sample's row is emitted straight after its head read, while a missing sample's row first
// reads back its neighbor slots one word per cycle from the buffer RAMs and then runs a
// bit-serial divide of SUM_BITS (53 at the default sizes) quotient bits. A row also waits
// while the output register still holds an unaccepted result.
// A finished row sits in an output register, so the next request is taken while it waits.
// window_rows (reset 5, saturating at MAX_WINDOW) is at byte address 0 and should be
// written only while the block is idle.
`default_nettype none

module windowed_mean_gap_filler_top #(
   parameter int MAX_WINDOW  = 16,
   parameter int SAMPLE_BITS = 48
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   wmgf_req_if.sink                                req_ch,
   wmgf_rsp_if.source                              rsp_ch,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [wmgf_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [wmgf_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [wmgf_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                    csr_pready
);

   logic [wmgf_pkg::WINDOW_BITS-1:0]    window_rows_ff, window_rows_in;
   logic [wmgf_pkg::REG_INDEX_BITS-1:0] csr_index;
   logic                                csr_write;
   wmgf_pkg::wmgf_cmd_type              cmd;
   wmgf_pkg::wmgf_status_type           status;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[wmgf_pkg::CSR_ADDR_BITS-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      window_rows_in = window_rows_ff;
      if (csr_write && (csr_index == wmgf_pkg::REG_WINDOW_ROWS)) begin
         window_rows_in = csr_pwdata[wmgf_pkg::WINDOW_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_rows_ff <= wmgf_pkg::WINDOW_BITS'(wmgf_pkg::WINDOW_RESET);
      end else begin
         window_rows_ff <= window_rows_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_index == wmgf_pkg::REG_WINDOW_ROWS) begin
         csr_prdata = wmgf_pkg::CSR_DATA_BITS'(window_rows_ff);
      end
   end

   wmgf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wmgf_datapath #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .window_rows (window_rows_ff),
      .req_value   (req_ch.sample_value),
      .req_missing (req_ch.sample_missing),
      .req_last    (req_ch.last_sample),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_value   (rsp_ch.out_value),
      .rsp_filled  (rsp_ch.out_filled),
      .rsp_last    (rsp_ch.out_last)
   );

   // one request in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while previous one still in work");

   // a row is only loaded when the output register can take it
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("emit would overwrite a waiting result");

   // head data is captured in the cycle after its read was issued
   assert property (@(posedge clock) disable iff (reset)
      cmd.head_load |-> $past(cmd.head_rd))
      else $error("head captured without a preceding read");

endmodule

`default_nettype wire

// ===== tb/windowed_mean_gap_filler_top_tb.sv =====
// Testbench for the windowed mean gap filler: directed and random column streams checked against a predictor.
module windowed_mean_gap_filler_top_tb;

   localparam int SB            = 48;
   localparam int MW            = 16;
   localparam int TOTAL_ITEMS   = 460;
   localparam int SETTLE_CYCLES = 200;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam logic [wmgf_pkg::CSR_ADDR_BITS-1:0] WINDOW_ADDR =
      wmgf_pkg::CSR_ADDR_BITS'(4 * wmgf_pkg::REG_WINDOW_ROWS);

   typedef struct packed {
      logic [SB-1:0] value;
      logic          missing;
      logic          last;
   } sample_req_type;

   typedef struct packed {
      logic [SB-1:0] value;
      logic          filled;
      logic          last;
   } gap_row_type;

   logic clock;
   logic reset;
   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [wmgf_pkg::CSR_ADDR_BITS-1:0]  csr_paddr;
   logic [wmgf_pkg::CSR_DATA_BITS-1:0]  csr_pwdata;
   logic [wmgf_pkg::CSR_DATA_BITS-1:0]  csr_prdata;
   logic                                csr_pready;

   wmgf_req_if #(.SAMPLE_BITS(SB)) req_bus ();
   wmgf_rsp_if #(.SAMPLE_BITS(SB)) rsp_bus ();

   windowed_mean_gap_filler_top #(
      .MAX_WINDOW  (MW),
      .SAMPLE_BITS (SB)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   logic [wmgf_pkg::WINDOW_BITS-1:0] win_setting;
   logic [SB-1:0]                    hist_vals [MW];
   int                               hist_cnt;
   logic [SB-1:0]                    pend_vals [MW+1];
   logic                             pend_absent [MW+1];
   int                               pend_cnt;

   sample_req_type sample_queue [$];
   gap_row_type    expected_rows [$];
   sample_req_type req_next;
   gap_row_type    row_want;

   int  mismatch_count;
   int  rows_seen;
   int  items_queued;
   int  cycle_count;
   int  req_gap;
   int  rsp_stall;
   bit  steady_run;
   int  window_plan [9] = '{16, 0, 1, 31, 2, 5, 17, 8, 3};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40) $display("mismatch: %s", msg);
   endtask

   function automatic void clear_column();
      hist_cnt = 0;
      pend_cnt = 0;
      for (int i = 0; i <= MW; i++) pend_absent[i] = 1'b0;
   endfunction

   function automatic void emit_filled_row(input int w, input bit is_last);
      gap_row_type   row;
      longint        acc;
      int            cnt;
      int            nb;
      int            nf;
      logic [SB-1:0] val;
      val = pend_vals[0];
      if (pend_absent[0]) begin
         acc = 0;
         cnt = 0;
         nb = (hist_cnt < w) ? hist_cnt : w;
         nf = pend_cnt - 1;
         if (nf > w) nf = w;
         for (int i = 0; i < nb; i++) begin
            acc += longint'($signed(hist_vals[i]));
            cnt++;
         end
         for (int i = 1; i <= nf; i++) begin
            if (!pend_absent[i]) begin
               acc += longint'($signed(pend_vals[i]));
               cnt++;
            end
         end
         val = (cnt == 0) ? '0 : SB'(acc / longint'(cnt));
      end
      row.value  = val;
      row.filled = pend_absent[0];
      row.last   = is_last;
      expected_rows = {expected_rows, row};
      for (int i = MW - 1; i > 0; i--) hist_vals[i] = hist_vals[i-1];
      hist_vals[0] = val;
      if (hist_cnt < MW) hist_cnt++;
      for (int i = 0; i < MW; i++) begin
         pend_vals[i]   = pend_vals[i+1];
         pend_absent[i] = pend_absent[i+1];
      end
      pend_cnt--;
   endfunction

   function automatic void predict_filled_rows(input logic [SB-1:0] v, input logic miss,
                                               input logic lst);
      int w;
      w = (int'(win_setting) > MW) ? MW : int'(win_setting);
      if (pend_cnt <= MW) begin
         pend_vals[pend_cnt]   = miss ? '0 : v;
         pend_absent[pend_cnt] = miss;
         pend_cnt++;
      end
      if (lst) begin
         while (pend_cnt > 0) emit_filled_row(w, pend_cnt == 1);
         clear_column();
      end else begin
         while (pend_cnt > w) emit_filled_row(w, 1'b0);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_run) return 0;
      if (r < 6) return $urandom_range(10, 40);
      if (r < 35) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic logic [SB-1:0] rand_sample();
      longint t;
      case ($urandom_range(0, 9))
         0: return {1'b0, {(SB-1){1'b1}}};
         1: return {1'b1, {(SB-1){1'b0}}};
         2: return '0;
         3: return '1;
         4, 5: begin
            t = longint'($urandom_range(0, 2000)) - 1000;
            return SB'(t * 65536);
         end
         default: return SB'({$urandom, $urandom});
      endcase
   endfunction

   task automatic queue_sample(input logic [SB-1:0] v, input logic miss, input logic lst);
      sample_req_type s;
      s.value   = v;
      s.missing = miss;
      s.last    = lst;
      sample_queue = {sample_queue, s};
      items_queued++;
   endtask

   task automatic queue_column(input int len, input int miss_pct, input bit close);
      for (int i = 0; i < len; i++)
         queue_sample(rand_sample(), $urandom_range(0, 99) < miss_pct, close && (i == len - 1));
   endtask

   task automatic wait_until_idle();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_bus.valid || expected_rows.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr,
                             input logic [wmgf_pkg::CSR_DATA_BITS-1:0] wdata,
                             output logic [wmgf_pkg::CSR_DATA_BITS-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= WINDOW_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_window_reg();
      logic [wmgf_pkg::CSR_DATA_BITS-1:0] rd;
      csr_access(1'b0, '0, rd);
      if (rd[wmgf_pkg::WINDOW_BITS-1:0] !== win_setting)
         report_mismatch($sformatf("window_rows read %0d, want %0d",
                                   rd[wmgf_pkg::WINDOW_BITS-1:0], win_setting));
   endtask

   task automatic set_window(input int w);
      logic [wmgf_pkg::CSR_DATA_BITS-1:0] rd;
      csr_access(1'b1, wmgf_pkg::CSR_DATA_BITS'(w), rd);
      win_setting = wmgf_pkg::WINDOW_BITS'(w);
      check_window_reg();
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap       <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            predict_filled_rows(req_bus.sample_value, req_bus.sample_missing,
                                req_bus.last_sample);
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap       <= req_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
               req_next               = sample_queue.pop_front();
               req_bus.sample_value   <= req_next.value;
               req_bus.sample_missing <= req_next.missing;
               req_bus.last_sample    <= req_next.last;
               req_bus.valid          <= 1'b1;
               req_gap                <= pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rows.size() == 0) begin
               report_mismatch($sformatf("row %0d unexpected: value %h", rows_seen,
                                         rsp_bus.out_value));
            end else begin
               row_want = expected_rows.pop_front();
               if (rsp_bus.out_value !== row_want.value)
                  report_mismatch($sformatf("row %0d out_value %h, want %h", rows_seen,
                                            rsp_bus.out_value, row_want.value));
               if (rsp_bus.out_filled !== row_want.filled)
                  report_mismatch($sformatf("row %0d out_filled %b, want %b", rows_seen,
                                            rsp_bus.out_filled, row_want.filled));
               if (rsp_bus.out_last !== row_want.last)
                  report_mismatch($sformatf("row %0d out_last %b, want %b", rows_seen,
                                            rsp_bus.out_last, row_want.last));
            end
            rows_seen++;
         end
         if (rsp_stall > 0) begin
            rsp_stall     <= rsp_stall - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!steady_run) begin
               case ($urandom_range(0, 99)) inside
                  [0:3]:   rsp_stall <= $urandom_range(10, 40);
                  [4:19]:  rsp_stall <= $urandom_range(1, 3);
                  default: rsp_stall <= 0;
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int phase;
      int ncols;
      int len;
      int pct;
      bit close;
      clock                  = 1'b0;
      reset                  = 1'b1;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;
      req_bus.valid          = 1'b0;
      req_bus.sample_value   = '0;
      req_bus.sample_missing = 1'b0;
      req_bus.last_sample    = 1'b0;
      rsp_bus.ready          = 1'b0;
      mismatch_count         = 0;
      rows_seen              = 0;
      items_queued           = 0;
      cycle_count            = 0;
      steady_run             = 1'b0;
      win_setting            = wmgf_pkg::WINDOW_BITS'(wmgf_pkg::WINDOW_RESET);
      clear_column();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset value, then directed columns at the default window
      check_window_reg();
      queue_sample(rand_sample(), 1'b1, 1'b1);
      queue_sample({1'b0, {(SB-1){1'b1}}}, 1'b0, 1'b1);
      queue_sample({1'b0, {(SB-1){1'b1}}}, 1'b0, 1'b0);
      queue_sample({1'b0, {(SB-1){1'b1}}}, 1'b0, 1'b0);
      queue_sample('1, 1'b1, 1'b0);
      queue_sample({1'b0, {(SB-1){1'b1}}}, 1'b0, 1'b0);
      queue_sample({1'b0, {(SB-1){1'b1}}}, 1'b0, 1'b1);
      queue_sample({1'b1, {(SB-1){1'b0}}}, 1'b0, 1'b0);
      queue_sample('0, 1'b1, 1'b0);
      queue_sample({1'b1, {(SB-1){1'b0}}}, 1'b0, 1'b1);
      queue_sample(rand_sample(), 1'b1, 1'b0);
      queue_sample(rand_sample(), 1'b1, 1'b0);
      queue_sample(rand_sample(), 1'b1, 1'b1);
      wait_until_idle();

      // zero window: a gap has no neighbors
      set_window(0);
      queue_sample(SB'(48'sd3 <<< 16), 1'b0, 1'b0);
      queue_sample(rand_sample(), 1'b1, 1'b0);
      queue_sample(SB'(-(48'sd7) <<< 16), 1'b0, 1'b1);
      wait_until_idle();

      // saturated window, then shrink mid-column
      set_window(31);
      queue_sample(SB'(48'sd5), 1'b0, 1'b0);
      queue_sample('1, 1'b1, 1'b0);
      queue_sample(SB'(-(48'sd2)), 1'b0, 1'b0);
      queue_sample(rand_sample(), 1'b1, 1'b0);
      wait_until_idle();
      set_window(1);
      queue_sample(rand_sample(), 1'b1, 1'b0);
      queue_sample(SB'(48'sd9), 1'b0, 1'b0);
      queue_sample(rand_sample(), 1'b1, 1'b1);

      phase = 0;
      while (items_queued < TOTAL_ITEMS) begin
         wait_until_idle();
         steady_run = ($urandom_range(0, 3) == 0);
         set_window((phase < 9) ? window_plan[phase] : $urandom_range(0, 31));
         ncols = $urandom_range(1, 3);
         for (int c = 0; c < ncols; c++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
            pct = ($urandom_range(0, 7) == 0) ? 90 : $urandom_range(5, 50);
            close = (c < ncols - 1) || ($urandom_range(0, 3) != 0);
            queue_column(len, pct, close);
         end
         phase++;
      end
      queue_sample(rand_sample(), 1'b0, 1'b1);
      wait_until_idle();

      if (expected_rows.size() != 0)
         report_mismatch($sformatf("%0d rows never arrived", expected_rows.size()));
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
